@@ src/cct_pkg.sv @@
`timescale 1ns / 1ps

package cct_pkg;

	localparam int NODE_W  = 10;
	localparam int COUNT_W = 11;

	// action codes on the item channel
	localparam logic ACT_EDGE  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// what the back end has to do with one request
	typedef enum logic [1:0] {
		JOB_EDGE  = 2'd0,
		JOB_QUERY = 2'd1,
		JOB_PASS  = 2'd2
	} job_kind_t;

	typedef struct packed {
		job_kind_t           kind;
		logic [NODE_W-1:0]   node_a;
		logic [NODE_W-1:0]   node_b;
	} job_t;

endpackage

@@ src/cct_if.sv @@
`timescale 1ns / 1ps

interface cct_item_if;
	import cct_pkg::*;

	logic              valid;
	logic              ready;
	logic              action;
	logic [NODE_W-1:0] node_a;
	logic [NODE_W-1:0] node_b;

	modport source (output valid, output action, output node_a, output node_b, input ready);
	modport sink (input valid, input action, input node_a, input node_b, output ready);
endinterface

interface cct_result_if;
	import cct_pkg::*;

	logic               valid;
	logic               ready;
	logic [NODE_W-1:0]  label;
	logic               node_known;
	logic [COUNT_W-1:0] component_count;
	logic               all_connected;

	modport source (output valid, output label, output node_known, output component_count,
		output all_connected, input ready);
	modport sink (input valid, input label, input node_known, input component_count,
		input all_connected, output ready);
endinterface

@@ src/connected_components_tracker.sv @@
`timescale 1ns / 1ps

// channel   dir  handshake      payload
// item      in   valid/ready    action, node_a, node_b
// result    out  valid/ready    label, node_known, component_count, all_connected
//
// every request gives one result; a query walks the parent chain of node_a and an edge
// the chains of both endpoints in the store, one link per cycle through the registered
// read port; a request with node_a out of range goes straight to its result
// after reset the store is swept once, one entry a cycle; item.ready
// stays low until the sweep ends
// a two-deep request queue lets the front take requests while the back end walks or
// while a result waits on a stalled result channel

module connected_components_tracker #(
	parameter int MAX_NODES = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	cct_item_if.sink     item,
	cct_result_if.source result
);
	import cct_pkg::*;

	logic clr_busy;
	logic job_valid;
	logic job_pop;
	job_t job;

	// front: range check of both endpoints, classification, request queue
	cct_front #(
		.MAX_NODES (MAX_NODES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.clr_busy  (clr_busy),
		.job_valid (job_valid),
		.job_pop   (job_pop),
		.job       (job)
	);

	// back: union-find over the parent store, smaller root wins a link,
	// component counter and the result register
	cct_back #(
		.MAX_NODES (MAX_NODES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_pop   (job_pop),
		.job       (job),
		.clr_busy  (clr_busy),
		.result    (result)
	);

	// no request taken while the store is being swept
	assert property (@(posedge clk) disable iff (!arst_n) clr_busy |-> !item.ready)
		else $error("request accepted during store sweep");

	// back end only pops a queued request
	assert property (@(posedge clk) disable iff (!arst_n) job_pop |-> job_valid)
		else $error("pop from empty request queue");

	// a known node belongs to at least one component
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.node_known |-> result.component_count != '0)
		else $error("known node with zero components");

	// component count never exceeds the node range
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> 32'(result.component_count) <= 32'(MAX_NODES))
		else $error("component count out of range");
endmodule

@@ src/cct_ram.sv @@
`timescale 1ns / 1ps

module cct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ src/cct_front.sv @@
`timescale 1ns / 1ps

module cct_front #(
	parameter int MAX_NODES = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	cct_item_if.sink      item,
	input  logic          clr_busy,
	output logic          job_valid,
	input  logic          job_pop,
	output cct_pkg::job_t job
);
	import cct_pkg::*;

	localparam int QDEPTH = 2;

	job_t                        entry_q [QDEPTH];
	logic [$clog2(QDEPTH)-1:0]   wr_ptr_q;
	logic [$clog2(QDEPTH)-1:0]   rd_ptr_q;
	logic [$clog2(QDEPTH+1)-1:0] fill_q;
	logic                        push;
	logic                        a_ok;
	logic                        b_ok;
	job_t                        new_job;

	// range check and classification of the incoming request
	assign a_ok = 32'(item.node_a) < 32'(MAX_NODES);
	assign b_ok = 32'(item.node_b) < 32'(MAX_NODES);

	always_comb begin
		new_job.node_a = item.node_a;
		new_job.node_b = item.node_b;
		if (item.action == ACT_EDGE && a_ok && b_ok) begin
			new_job.kind = JOB_EDGE;
		end else if (a_ok) begin
			new_job.kind = JOB_QUERY;
		end else begin
			new_job.kind = JOB_PASS;
		end
	end

	assign item.ready = !clr_busy && (fill_q != ($clog2(QDEPTH+1))'(QDEPTH));
	assign push       = item.valid && item.ready;
	assign job_valid  = fill_q != '0;
	assign job        = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (job_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !job_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (!push && job_pop) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_job;
		end
	end
endmodule

@@ src/cct_back.sv @@
`timescale 1ns / 1ps

module cct_back #(
	parameter int MAX_NODES = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_pop,
	input  cct_pkg::job_t job,
	output logic          clr_busy,
	cct_result_if.source  result
);
	import cct_pkg::*;

	localparam int AW     = $clog2(MAX_NODES);
	localparam int WORD_W = AW + 1;

	typedef enum logic [7:0] {
		S_CLEAR  = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_RD_A   = 8'b0000_0100,
		S_RD_B   = 8'b0000_1000,
		S_WALK_A = 8'b0001_0000,
		S_WALK_B = 8'b0010_0000,
		S_LINK   = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t             state_q;
	state_t             state_d;
	logic [AW-1:0]      clr_q;
	logic [COUNT_W-1:0] cnt_q;
	logic               res_valid_q;
	job_t               job_q;
	logic [AW-1:0]      cur_q;
	logic [AW-1:0]      ra_q;
	logic [NODE_W-1:0]  label_q;
	logic               known_q;
	logic [NODE_W-1:0]  res_label_q;
	logic               res_known_q;
	logic [COUNT_W-1:0] res_count_q;

	logic              we;
	logic [AW-1:0]     waddr;
	logic [WORD_W-1:0] wdata;
	logic [AW-1:0]     raddr;
	logic [WORD_W-1:0] rdata;

	logic [AW-1:0] rd_par;
	logic          rd_seen;
	logic [AW-1:0] a_addr;
	logic [AW-1:0] b_addr;
	logic          is_edge;
	logic          walk_hit;
	logic          b_seen;
	logic [AW-1:0] root_lo;
	logic [AW-1:0] root_hi;
	logic          out_free;

	// word layout: seen flag on top, parent pointer below
	cct_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_NODES)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_par   = rdata[AW-1:0];
	assign rd_seen  = rdata[AW];
	assign a_addr   = AW'(job_q.node_a);
	assign b_addr   = AW'(job_q.node_b);
	assign is_edge  = job_q.kind == JOB_EDGE;
	assign walk_hit = rd_par == cur_q;
	// a self loop: a is marked by the write issued with the read of b, so that read still shows the old flag
	assign b_seen   = rd_seen || (job_q.node_a == job_q.node_b);
	assign root_lo  = (ra_q < cur_q) ? ra_q : cur_q;
	assign root_hi  = (ra_q < cur_q) ? cur_q : ra_q;
	assign out_free = !res_valid_q || result.ready;
	assign clr_busy = state_q == S_CLEAR;

	always_comb begin
		state_d = state_q;
		job_pop = 1'b0;
		we      = 1'b0;
		waddr   = clr_q;
		wdata   = {1'b0, clr_q};
		raddr   = a_addr;
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				if (clr_q == AW'(MAX_NODES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				raddr = AW'(job.node_a);
				if (job_valid) begin
					job_pop = 1'b1;
					state_d = (job.kind == JOB_PASS) ? S_DONE : S_RD_A;
				end
			end
			S_RD_A: begin
				if (is_edge) begin
					raddr   = b_addr;
					state_d = S_RD_B;
					if (!rd_seen) begin
						we    = 1'b1;
						waddr = a_addr;
						wdata = {1'b1, rd_par};
					end
				end else begin
					state_d = S_WALK_A;
				end
			end
			S_RD_B: begin
				state_d = S_WALK_A;
				if (!b_seen) begin
					we    = 1'b1;
					waddr = b_addr;
					wdata = {1'b1, rd_par};
				end
			end
			S_WALK_A: begin
				raddr = rd_par;
				if (walk_hit) begin
					raddr   = b_addr;
					state_d = is_edge ? S_WALK_B : S_DONE;
				end
			end
			S_WALK_B: begin
				raddr = rd_par;
				if (walk_hit) begin
					state_d = S_LINK;
				end
			end
			S_LINK: begin
				state_d = S_DONE;
				if (ra_q != cur_q) begin
					we    = 1'b1;
					waddr = root_hi;
					wdata = {1'b1, root_lo};
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == S_RD_A && is_edge && !rd_seen) begin
				cnt_q <= cnt_q + COUNT_W'(1);
			end else if (state_q == S_RD_B && !b_seen) begin
				cnt_q <= cnt_q + COUNT_W'(1);
			end else if (state_q == S_LINK && ra_q != cur_q && cnt_q != '0) begin
				cnt_q <= cnt_q - COUNT_W'(1);
			end
			if (state_q == S_DONE && out_free) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (job_valid) begin
					job_q   <= job;
					label_q <= job.node_a;
					known_q <= 1'b0;
				end
			end
			S_RD_A: begin
				known_q <= is_edge ? 1'b1 : rd_seen;
				cur_q   <= a_addr;
			end
			S_RD_B: begin
				cur_q <= a_addr;
			end
			S_WALK_A: begin
				if (walk_hit) begin
					ra_q    <= cur_q;
					label_q <= NODE_W'(cur_q);
					cur_q   <= b_addr;
				end else begin
					cur_q <= rd_par;
				end
			end
			S_WALK_B: begin
				if (!walk_hit) begin
					cur_q <= rd_par;
				end
			end
			S_LINK: begin
				label_q <= NODE_W'(root_lo);
			end
			S_DONE: begin
				if (out_free) begin
					res_label_q <= label_q;
					res_known_q <= known_q;
					res_count_q <= cnt_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result.valid           = res_valid_q;
	assign result.label           = res_label_q;
	assign result.node_known      = res_known_q;
	assign result.component_count = res_count_q;
	assign result.all_connected   = res_count_q == COUNT_W'(1);
endmodule
